// ===== design/indexed_list_buffer_unit_defines.svh =====
// assertion macros for the indexed list buffer
`ifndef INDEXED_LIST_BUFFER_UNIT_DEFINES_SVH
`define INDEXED_LIST_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define ILB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ILB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ilb_pkg.sv =====
package ilb_pkg;

   localparam int DATA_W = 32;
   localparam logic [DATA_W-1:0] ERR_DATA = {DATA_W{1'b1}};

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SET    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SET    = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         at_idx;
      logic         past_idx;
   } cell_ctl_type;

endpackage

// ===== design/ilb_cell.sv =====
module ilb_cell (
   input  logic                       clock,
   input  ilb_pkg::cell_ctl_type      ctl,
   input  logic [ilb_pkg::DATA_W-1:0] new_value,
   input  logic [ilb_pkg::DATA_W-1:0] left_data,
   input  logic [ilb_pkg::DATA_W-1:0] right_data,
   output logic [ilb_pkg::DATA_W-1:0] data
);

   logic [ilb_pkg::DATA_W-1:0] data_ff;
   logic [ilb_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.cmd)
         ilb_pkg::CMD_HOLD: begin
            data_in = data_ff;
         end
         ilb_pkg::CMD_INSERT: begin
            if (ctl.at_idx) begin
               data_in = new_value;
            end else if (ctl.past_idx) begin
               data_in = left_data;
            end
         end
         ilb_pkg::CMD_REMOVE: begin
            if (ctl.at_idx || ctl.past_idx) begin
               data_in = right_data;
            end
         end
         ilb_pkg::CMD_SET: begin
            if (ctl.at_idx) begin
               data_in = new_value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/indexed_list_buffer_unit.sv =====
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle; every cell shifts in parallel with its neighbors
// busy stays low, so start may be held high every cycle
// synchronous reset empties the list; entry contents are left as they are
// results cannot be stalled by the receiver
`include "indexed_list_buffer_unit_defines.svh"

module indexed_list_buffer_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [$clog2(DEPTH+1)-1:0]           req_index,
   input  logic signed [ilb_pkg::DATA_W-1:0]    req_value,
   output logic                                 rsp_valid,
   output logic signed [ilb_pkg::DATA_W-1:0]    rsp_data,
   output logic [1:0]                           rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_count,
   output logic                                 rsp_empty_res
);

   localparam int IW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [IW-1:0]                cnt_ff;
   logic [IW-1:0]                cnt_in;
   logic                         rsp_valid_ff;
   logic [ilb_pkg::DATA_W-1:0]   rsp_data_ff;
   logic [ilb_pkg::DATA_W-1:0]   rsp_data_in;
   ilb_pkg::status_type          rsp_status_ff;
   ilb_pkg::status_type          rsp_status_in;
   logic [IW-1:0]                rsp_count_ff;

   logic                         accept;
   ilb_pkg::op_type              op;
   logic                         range_err;
   logic                         full;
   logic                         do_op;
   ilb_pkg::cell_cmd_type        cmd;
   logic [ilb_pkg::DATA_W-1:0]   read_data;
   logic [ilb_pkg::DATA_W-1:0]   cell_data [DEPTH];
   ilb_pkg::cell_ctl_type        cell_ctl [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = ilb_pkg::op_type'(req_operation);
   assign full   = (cnt_ff == IW'(DEPTH));

   always_comb begin
      range_err = (req_index >= cnt_ff);
      if (op == ilb_pkg::OP_INSERT) begin
         range_err = (req_index > cnt_ff);
      end
   end

   assign read_data = cell_data[req_index[AW-1:0]];

   always_comb begin
      do_op         = 1'b0;
      cmd           = ilb_pkg::CMD_HOLD;
      cnt_in        = cnt_ff;
      rsp_data_in   = ilb_pkg::ERR_DATA;
      rsp_status_in = ilb_pkg::ST_OK;
      if (range_err) begin
         rsp_status_in = ilb_pkg::ST_RANGE;
      end else if (op == ilb_pkg::OP_INSERT && full) begin
         rsp_status_in = ilb_pkg::ST_FULL;
      end else begin
         do_op = accept;
         unique case (op)
            ilb_pkg::OP_GET: begin
               rsp_data_in = read_data;
            end
            ilb_pkg::OP_INSERT: begin
               rsp_data_in = '0;
               cmd         = ilb_pkg::CMD_INSERT;
               cnt_in      = cnt_ff + IW'(1);
            end
            ilb_pkg::OP_REMOVE: begin
               rsp_data_in = read_data;
               cmd         = ilb_pkg::CMD_REMOVE;
               cnt_in      = cnt_ff - IW'(1);
            end
            ilb_pkg::OP_SET: begin
               rsp_data_in = '0;
               cmd         = ilb_pkg::CMD_SET;
            end
            default: begin
               rsp_data_in = ilb_pkg::ERR_DATA;
            end
         endcase
      end
      if (!do_op) begin
         cmd    = ilb_pkg::CMD_HOLD;
         cnt_in = cnt_ff;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ilb_pkg::DATA_W-1:0] left_data;
      logic [ilb_pkg::DATA_W-1:0] right_data;

      assign cell_ctl[g].cmd      = cmd;
      assign cell_ctl[g].at_idx   = (req_index == IW'(g));
      assign cell_ctl[g].past_idx = (IW'(g) > req_index);

      if (g == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_mid_left
         assign left_data = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_mid_right
         assign right_data = cell_data[g+1];
      end

      ilb_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .new_value  (req_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= cnt_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = (rsp_count_ff == '0);

   `ILB_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, cnt_ff <= IW'(DEPTH), "count above depth")
   `ILB_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid, "request without response")
   `ILB_ASSERT_NEXT(a_insert_count, clock, reset,
      do_op && op == ilb_pkg::OP_INSERT,
      cnt_ff == $past(cnt_ff) + IW'(1), "insert did not grow list")
   `ILB_ASSERT_NEXT(a_error_hold, clock, reset, accept && !do_op,
      cnt_ff == $past(cnt_ff) && rsp_data == ilb_pkg::ERR_DATA,
      "refused request changed state")

endmodule

// ===== tb/sv/tb_indexed_list_buffer_unit.sv =====
`timescale 1ns / 1ps

module tb_indexed_list_buffer_unit;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct {
      logic signed [ilb_pkg::DATA_W-1:0] data;
      ilb_pkg::status_type               status;
      logic [CNT_W-1:0]                  count;
      logic                              empty_res;
   } list_result_type;

   class list_scoreboard_type;
      logic signed [ilb_pkg::DATA_W-1:0] slots [DEPTH];
      int unsigned                       fill;
      list_result_type                   awaited [$];
      int unsigned                       fail_count;

      function new();
         fill = 0;
         fail_count = 0;
      endfunction

      // applies one accepted request to the list copy and queues its result
      function void note_request(ilb_pkg::op_type op, logic [CNT_W-1:0] idx,
                                 logic signed [ilb_pkg::DATA_W-1:0] val);
         list_result_type r;
         int unsigned     pos;
         pos = idx;
         r.data = '0;
         r.status = ilb_pkg::ST_OK;
         case (op)
            ilb_pkg::OP_GET: begin
               if (pos >= fill) begin
                  r.data = ilb_pkg::ERR_DATA;
                  r.status = ilb_pkg::ST_RANGE;
               end else begin
                  r.data = slots[pos];
               end
            end
            ilb_pkg::OP_INSERT: begin
               if (pos > fill) begin
                  r.data = ilb_pkg::ERR_DATA;
                  r.status = ilb_pkg::ST_RANGE;
               end else if (fill >= DEPTH) begin
                  r.data = ilb_pkg::ERR_DATA;
                  r.status = ilb_pkg::ST_FULL;
               end else begin
                  for (int unsigned i = fill; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos] = val;
                  fill++;
               end
            end
            ilb_pkg::OP_REMOVE: begin
               if (pos >= fill) begin
                  r.data = ilb_pkg::ERR_DATA;
                  r.status = ilb_pkg::ST_RANGE;
               end else begin
                  r.data = slots[pos];
                  for (int unsigned i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            default: begin
               if (pos >= fill) begin
                  r.data = ilb_pkg::ERR_DATA;
                  r.status = ilb_pkg::ST_RANGE;
               end else begin
                  slots[pos] = val;
               end
            end
         endcase
         r.count = CNT_W'(fill);
         r.empty_res = (fill == 0);
         awaited.push_back(r);
      endfunction

      function void check_result(logic signed [ilb_pkg::DATA_W-1:0] data,
                                 logic [1:0] status,
                                 logic [CNT_W-1:0] count, logic empty_res);
         list_result_type r;
         if (awaited.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
            return;
         end
         r = awaited.pop_front();
         if (data !== r.data) begin
            $error("rsp_data: expected %0d, got %0d", r.data, data);
            fail_count++;
         end
         if (status !== r.status) begin
            $error("rsp_status: expected %0d, got %0d", r.status, status);
            fail_count++;
         end
         if (count !== r.count) begin
            $error("rsp_count: expected %0d, got %0d", r.count, count);
            fail_count++;
         end
         if (empty_res !== r.empty_res) begin
            $error("rsp_empty_res: expected %0d, got %0d", r.empty_res, empty_res);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [1:0]                        req_operation = '0;
   logic [CNT_W-1:0]                  req_index = '0;
   logic signed [ilb_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic signed [ilb_pkg::DATA_W-1:0] rsp_data;
   logic [1:0]                        rsp_status;
   logic [CNT_W-1:0]                  rsp_count;
   logic                              rsp_empty_res;

   list_scoreboard_type board = new();
   int unsigned         sender_idle_pct = 0;

   indexed_list_buffer_unit #(.DEPTH(DEPTH)) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_result(rsp_data, rsp_status, rsp_count, rsp_empty_res);
   end

   // called at a rising edge; returns at the edge that accepts the request
   task automatic issue(ilb_pkg::op_type op, int unsigned idx,
                        logic signed [ilb_pkg::DATA_W-1:0] val);
      int unsigned gap;
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_index <= idx[CNT_W-1:0];
      req_value <= val;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_request(op, idx[CNT_W-1:0], val);
   endtask

   function automatic logic signed [ilb_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_request(ref bit growing);
      int unsigned     roll;
      int unsigned     idx;
      ilb_pkg::op_type op;
      if (board.fill >= DEPTH) growing = 1'b0;
      if (board.fill == 0) growing = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 55) op = growing ? ilb_pkg::OP_INSERT : ilb_pkg::OP_REMOVE;
      else if (roll < 70) op = ilb_pkg::OP_GET;
      else if (roll < 85) op = ilb_pkg::OP_SET;
      else op = growing ? ilb_pkg::OP_REMOVE : ilb_pkg::OP_INSERT;
      if ($urandom_range(0, 99) < 15 || board.fill == 0)
         idx = $urandom_range(0, DEPTH);
      else if (op == ilb_pkg::OP_INSERT)
         idx = $urandom_range(0, board.fill);
      else
         idx = $urandom_range(0, board.fill - 1);
      issue(op, idx, pick_value());
   endtask

   initial begin
      int unsigned idle_plan [4];
      bit          growing;
      idle_plan = '{0, 75, 0, 38};
      growing = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list errors
      issue(ilb_pkg::OP_GET, 0, 32'sd5);
      issue(ilb_pkg::OP_REMOVE, 0, 32'sd5);
      issue(ilb_pkg::OP_SET, 0, 32'sd5);
      issue(ilb_pkg::OP_INSERT, 1, 32'sd5);
      // fill to capacity at front, back and middle
      for (int unsigned k = 0; k < DEPTH; k++)
         issue(ilb_pkg::OP_INSERT, (k % 3 == 0) ? 0 : ((k % 3 == 1) ? k : k / 2),
               (k == 0) ? 32'sh7FFF_FFFF : ((k == 1) ? 32'sh8000_0000 : $urandom));
      // full list and range checks, then set, get and remove at back and front
      issue(ilb_pkg::OP_INSERT, DEPTH, 32'sd7);
      issue(ilb_pkg::OP_INSERT, 3, 32'sd7);
      issue(ilb_pkg::OP_GET, DEPTH, 32'sd0);
      issue(ilb_pkg::OP_SET, DEPTH - 1, -32'sd1);
      issue(ilb_pkg::OP_GET, DEPTH - 1, 32'sd0);
      issue(ilb_pkg::OP_REMOVE, DEPTH - 1, 32'sd0);
      issue(ilb_pkg::OP_REMOVE, 0, 32'sd0);

      foreach (idle_plan[p]) begin
         sender_idle_pct = idle_plan[p];
         repeat (125) random_request(growing);
      end

      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
